>>> hw/rtl/overwriting_ring_offset_lookup_macros.svh
// Assertion macros used by the ring offset lookup datapath
`ifndef OVERWRITING_RING_OFFSET_LOOKUP_MACROS_SVH
`define OVERWRITING_RING_OFFSET_LOOKUP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define OROL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define OROL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/orol_pkg.sv
// Package: sizes, item types and controller/datapath signal groups
`timescale 1ns / 1ps

package orol_pkg;

  localparam int DEPTH       = 16;
  localparam int SIZE_BITS   = 16;
  localparam int HANDLE_BITS = 32;

  localparam int OFF_W    = 20;
  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 16;
  localparam int SLOT_W   = 4;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ACC_W = (OFF_W > SIZE_BITS + CNT_W) ? OFF_W : SIZE_BITS + CNT_W;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [SIZE_BITS-1:0]   size;
  } entry_t;

  typedef struct packed {
    logic                opcode;
    logic [HANDLE_W-1:0] entry_handle;
    logic [SIZE_W-1:0]   entry_size;
    logic [OFF_W-1:0]    find_offset;
  } in_item_t;

  typedef struct packed {
    logic                evicted_valid;
    logic [HANDLE_W-1:0] evicted_handle;
    logic                found;
    logic [SLOT_W-1:0]   found_slot;
    logic [HANDLE_W-1:0] found_handle;
    logic [SIZE_W-1:0]   byte_in_entry;
  } out_item_t;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  typedef struct packed {
    logic start;
    logic add_commit;
    logic find_step;
    logic find_done;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_find;
    logic walk_end;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/orol_in_if.sv
// Input channel: valid/ready handshake carrying one request item
`timescale 1ns / 1ps

interface orol_in_if import orol_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/orol_out_if.sv
// Output channel: valid/ready handshake carrying one result item
`timescale 1ns / 1ps

interface orol_out_if import orol_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/orol_ctrl.sv
// Controller: sequences add and find items over the datapath
`timescale 1ns / 1ps

module orol_ctrl import orol_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADD  = 4'b0010,
    ST_FIND = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.in_find ? ST_FIND : ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.add_commit = 1'b1;
        state_d          = ST_DONE;
      end
      ST_FIND: begin
        if (sts_i.walk_end || sts_i.hit) begin
          cmd_o.find_done = 1'b1;
          state_d         = ST_DONE;
        end else begin
          cmd_o.find_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/orol_dp.sv
// Datapath: entry ring memory, ring indices, offset walk and result register
`timescale 1ns / 1ps
`include "overwriting_ring_offset_lookup_macros.svh"

module orol_dp import orol_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  logic      out_ready_i
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_LAST) ? '0 : idx + 1'b1;
  endfunction

  entry_t mem_q [DEPTH];
  entry_t rd_q;

  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             full_q, full_d;
  logic [CNT_W-1:0] cnt_q, count_q;
  logic             out_valid_q;

  logic [HANDLE_BITS-1:0] handle_q;
  logic [SIZE_BITS-1:0]   size_q;
  logic [OFF_W-1:0]       off_q;
  logic [IDX_W-1:0]       ptr_q, ptr_next;
  logic [ACC_W-1:0]       pos_q;
  out_item_t              res_q, out_q;

  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic [ACC_W-1:0] off_ext, size_ext, diff;
  logic             hit;
  logic [CNT_W-1:0] count_now;

  assign ptr_next  = idx_inc(ptr_q);
  assign rd_en     = cmd_i.start | cmd_i.find_step;
  assign rd_addr   = cmd_i.find_step ? ptr_next : rd_idx_q;
  assign count_now = full_q ? CNT_W'(DEPTH) : CNT_W'(wr_idx_q);

  assign off_ext  = ACC_W'(off_q);
  assign size_ext = ACC_W'(rd_q.size);
  assign diff     = off_ext - pos_q;
  assign hit      = (off_ext >= pos_q) && (diff < size_ext);

  assign sts_o.in_find  = (in_item_i.opcode == OP_FIND);
  assign sts_o.walk_end = (cnt_q == count_q);
  assign sts_o.hit      = hit;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    full_d   = full_q;
    if (cmd_i.add_commit) begin
      wr_idx_d = idx_inc(wr_idx_q);
      if (full_q) begin
        rd_idx_d = idx_inc(rd_idx_q);
      end
      full_d = full_q || (wr_idx_d == rd_idx_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_commit) begin
      mem_q[wr_idx_q] <= '{handle: handle_q, size: size_q};
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      full_q      <= 1'b0;
      cnt_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      full_q   <= full_d;
      if (cmd_i.start) begin
        cnt_q   <= '0;
        count_q <= count_now;
      end else if (cmd_i.find_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      handle_q <= HANDLE_BITS'(in_item_i.entry_handle);
      size_q   <= SIZE_BITS'(in_item_i.entry_size);
      off_q    <= in_item_i.find_offset;
      ptr_q    <= rd_idx_q;
      pos_q    <= '0;
    end else if (cmd_i.find_step) begin
      ptr_q <= ptr_next;
      pos_q <= pos_q + size_ext;
    end
    if (cmd_i.add_commit) begin
      res_q.evicted_valid  <= full_q;
      res_q.evicted_handle <= full_q ? HANDLE_W'(rd_q.handle) : '0;
      res_q.found          <= 1'b0;
      res_q.found_slot     <= '0;
      res_q.found_handle   <= '0;
      res_q.byte_in_entry  <= '0;
    end else if (cmd_i.find_done) begin
      res_q.evicted_valid  <= 1'b0;
      res_q.evicted_handle <= '0;
      if (hit && !sts_o.walk_end) begin
        res_q.found         <= 1'b1;
        res_q.found_slot    <= SLOT_W'(ptr_q);
        res_q.found_handle  <= HANDLE_W'(rd_q.handle);
        res_q.byte_in_entry <= SIZE_W'(diff);
      end else begin
        res_q.found         <= 1'b0;
        res_q.found_slot    <= '0;
        res_q.found_handle  <= '0;
        res_q.byte_in_entry <= '0;
      end
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `OROL_ASSERT_NOW(a_full_idx_eq, full_q, rd_idx_q == wr_idx_q, "full ring with split indices")
  `OROL_ASSERT_NOW(a_empty_rd_zero, !full_q, rd_idx_q == '0, "read index moved before full")
  `OROL_ASSERT_NOW(a_walk_bound, 1'b1, cnt_q <= count_q, "walk ran past stored entries")
  `OROL_ASSERT_NOW(a_res_exclusive, out_valid_q && out_q.found, !out_q.evicted_valid,
                   "result both found and evicted")
  `OROL_ASSERT_NEXT(a_add_advance, cmd_i.add_commit, wr_idx_q == $past(idx_inc(wr_idx_q)),
                    "write index did not advance on add")

endmodule

>>> hw/rtl/overwriting_ring_offset_lookup.sv
// Ring of handle/size entries with overwrite on full and offset lookup.
// An add writes its entry and result in the add state; a find walks from the oldest entry until
// a hit or the end of the stored data (at most DEPTH entries), one ring entry per cycle. Each
// result is then loaded into the output register once it is free; the next item is accepted only
// after that load, so a result waiting in the output register holds off the next item.
// Reset empties the ring (indices and full flag cleared); entry storage is not cleared.
`timescale 1ns / 1ps

module overwriting_ring_offset_lookup import orol_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  orol_in_if.sink    in_i,
  orol_out_if.source out_o
);

  cmd_t      cmd;
  sts_t      sts;
  logic      out_valid;
  out_item_t out_item;

  orol_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  orol_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_i.payload),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .out_ready_i (out_o.ready)
  );

  assign out_o.valid   = out_valid;
  assign out_o.payload = out_item;

endmodule
